### hw/rtl/uetu_pkg.sv
// Package for the unicode escape to UTF-8 unit: byte codes, the burst
// descriptor that front and back exchange, and hex digit helpers.
// No dependencies.
package uetu_pkg;

  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_U      = 8'h75;

  localparam int MAX_OUT     = 6;  // most bytes one input can release
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Bytes one input byte turns into; cnt 0 with last set is a bare end marker.
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] data;
    logic [2:0]              cnt;
    logic                    last;
  } desc_t;

  function automatic logic is_hex(input logic [7:0] b);
    return (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [3:0] v;
    v = 4'd0;
    if (b inside {[8'h30:8'h39]}) v = b[3:0];
    else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) v = b[3:0] + 4'd9;
    return v;
  endfunction

endpackage

### hw/rtl/unicode_escape_to_utf8_unit.sv
// Decodes \uXXXX escapes in a byte stream into 1 to 3 UTF-8 bytes; surrogate
// code points are dropped, and broken or all-zero escapes pass through as
// they came. The input takes one byte per cycle while the 4-entry descriptor
// queue has room. The output gives one byte per cycle while m_tready is high;
// a descriptor stays at the queue head until all of its bytes are sent, a bare
// end marker giving one beat, so sustained rate is one input per cycle for
// plain text. An input byte passes the descriptor queue, then the output register.
module unicode_escape_to_utf8_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte
  input  logic       s_tlast,   // in_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic       m_tuser,   // byte_valid
  output logic       m_tlast    // out_last
);
  import uetu_pkg::*;

  desc_t push_desc, head;
  logic  push, pop, q_full, q_empty;

  uetu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .push      (push),
    .push_desc (push_desc),
    .q_full    (q_full)
  );

  uetu_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (push_desc),
    .full    (q_full),
    .pop     (pop),
    .rd_data (head),
    .empty   (q_empty)
  );

  uetu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

### hw/rtl/uetu_front.sv
// Front end: accepts text bytes, tracks the escape being collected and
// turns the bytes into descriptors of up to six output bytes each.
// Depends on uetu_pkg.
module uetu_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // in_byte
  input  logic                 s_tlast,   // in_last
  output logic                 push,
  output uetu_pkg::desc_t      push_desc,
  input  logic                 q_full
);
  import uetu_pkg::*;

  logic [2:0]  held_count, held_count_next;
  logic [15:0] partial_code, partial_code_next;
  logic [7:0]  held_hex [3];

  logic        accept;
  logic        hex_ok;
  logic [3:0]  hv;
  logic [15:0] cp;
  logic        fresh;
  logic        wr_hex;
  logic [1:0]  wr_idx;
  logic [2:0]  rel_n, mid_n, tail_n;
  logic [7:0]  mid [3];
  logic [7:0]  seq_old [5];
  logic [7:0]  seq_new [5];
  logic [7:0]  slot [MAX_OUT];
  logic [3:0]  pos;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !q_full;
  assign hex_ok   = is_hex(s_tdata);
  assign hv       = hex_val(s_tdata);
  assign wr_idx   = 2'(held_count - 3'd2);
  assign cp       = partial_code | 16'(hv);

  always_comb begin
    held_count_next   = held_count;
    partial_code_next = partial_code;
    fresh  = 1'b0;
    wr_hex = 1'b0;
    rel_n  = 3'd0;
    mid_n  = 3'd0;
    tail_n = 3'd0;
    for (int j = 0; j < 3; j++) mid[j] = 8'h00;

    case (held_count)
      3'd1: begin
        if (s_tdata == CHAR_U) held_count_next = 3'd2;
        else begin
          rel_n = 3'd1;
          fresh = 1'b1;
        end
      end
      3'd2, 3'd3, 3'd4: begin
        if (hex_ok) begin
          wr_hex            = 1'b1;
          partial_code_next = partial_code | (16'(hv) << {2'd3 - wr_idx, 2'b00});
          held_count_next   = held_count + 3'd1;
        end else begin
          rel_n = held_count;
          fresh = 1'b1;
        end
      end
      3'd5: begin
        if (hex_ok) begin
          held_count_next   = 3'd0;
          partial_code_next = 16'd0;
          if (cp == 16'd0) begin
            // all-zero escape is passed on verbatim
            rel_n  = 3'd5;
            mid[0] = s_tdata;
            mid_n  = 3'd1;
          end else if (cp <= 16'h007F) begin
            mid[0] = cp[7:0];
            mid_n  = 3'd1;
          end else if (cp <= 16'h07FF) begin
            mid[0] = {3'b110, cp[10:6]};
            mid[1] = {2'b10, cp[5:0]};
            mid_n  = 3'd2;
          end else if (cp >= 16'hD800 && cp <= 16'hDFFF) begin
            mid_n = 3'd0;  // surrogate: dropped
          end else begin
            mid[0] = {4'b1110, cp[15:12]};
            mid[1] = {2'b10, cp[11:6]};
            mid[2] = {2'b10, cp[5:0]};
            mid_n  = 3'd3;
          end
        end else begin
          rel_n = 3'd5;
          fresh = 1'b1;
        end
      end
      default: fresh = 1'b1;
    endcase

    if (fresh) begin
      partial_code_next = 16'd0;
      if (s_tdata == CHAR_BSLASH) held_count_next = 3'd1;
      else begin
        held_count_next = 3'd0;
        mid[0] = s_tdata;
        mid_n  = 3'd1;
      end
    end

    seq_old[0] = CHAR_BSLASH;
    seq_old[1] = CHAR_U;
    seq_new[0] = CHAR_BSLASH;
    seq_new[1] = CHAR_U;
    for (int j = 0; j < 3; j++) begin
      seq_old[j+2] = held_hex[j];
      seq_new[j+2] = (wr_hex && wr_idx == 2'(j)) ? s_tdata : held_hex[j];
    end

    // end of string flushes whatever is still held
    if (s_tlast) begin
      tail_n            = held_count_next;
      held_count_next   = 3'd0;
      partial_code_next = 16'd0;
    end

    for (int i = 0; i < MAX_OUT; i++) slot[i] = 8'h00;
    for (int i = 0; i < 5; i++)
      if (3'(i) < rel_n) slot[i] = seq_old[i];
    for (int j = 0; j < 3; j++) begin
      pos = 4'(rel_n) + 4'(j);
      if (3'(j) < mid_n && pos < 4'(MAX_OUT)) slot[pos[2:0]] = mid[j];
    end
    for (int i = 0; i < 5; i++) begin
      pos = 4'(rel_n) + 4'(mid_n) + 4'(i);
      if (3'(i) < tail_n && pos < 4'(MAX_OUT)) slot[pos[2:0]] = seq_new[i];
    end

    for (int i = 0; i < MAX_OUT; i++) push_desc.data[i] = slot[i];
    push_desc.cnt  = rel_n + mid_n + tail_n;
    push_desc.last = s_tlast;
  end

  assign push = accept && (push_desc.cnt != 3'd0 || s_tlast);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count   <= 3'd0;
      partial_code <= 16'd0;
    end else if (accept) begin
      held_count   <= held_count_next;
      partial_code <= partial_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_hex) held_hex[wr_idx] <= s_tdata;
  end

`ifndef SYNTHESIS
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> held_count == 3'd0)
    else $error("escape still held after end of string");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    push |-> push_desc.cnt <= 3'(MAX_OUT))
    else $error("descriptor byte count out of range");

  a_plain_passes: assert property (@(posedge clk) disable iff (rst)
    accept && held_count == 3'd0 && s_tdata != CHAR_BSLASH |-> push)
    else $error("plain byte produced no output");
`endif

endmodule

### hw/rtl/uetu_fifo.sv
// Short descriptor queue between the front and back ends.
// Depends on uetu_pkg.
module uetu_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  uetu_pkg::desc_t wr_data,
  output logic            full,
  input  logic            pop,
  output uetu_pkg::desc_t rd_data,
  output logic            empty
);
  import uetu_pkg::*;

  desc_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= wr_data;
  end

endmodule

### hw/rtl/uetu_back.sv
// Back end: walks the head descriptor one byte per cycle, while the output
// can load, into the registered output stream. Depends on uetu_pkg.
module uetu_back (
  input  logic            clk,
  input  logic            rst,
  input  uetu_pkg::desc_t head,
  input  logic            empty,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,   // out_byte
  output logic            m_tuser,   // byte_valid
  output logic            m_tlast    // out_last
);
  import uetu_pkg::*;

  logic [2:0] idx;
  logic       load;
  logic       fin;

  assign load = !m_tvalid || m_tready;
  assign fin  = (head.cnt == 3'd0) || (idx == head.cnt - 3'd1);
  assign pop  = load && !empty && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= 3'd0;
    end else if (load) begin
      m_tvalid <= !empty;
      if (pop)         idx <= 3'd0;
      else if (!empty) idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= (head.cnt == 3'd0) ? 8'h00 : head.data[idx];
      m_tuser <= (head.cnt != 3'd0);
      m_tlast <= head.last && fin;
    end
  end

`ifndef SYNTHESIS
  a_bare_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast)
    else $error("bare end marker without last");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (idx < head.cnt || idx == 3'd0))
    else $error("byte index past descriptor");

  a_load_fills: assert property (@(posedge clk) disable iff (rst)
    load && !empty |=> m_tvalid)
    else $error("queued descriptor not presented");
`endif

endmodule
